>>> design/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// shared types, constants and helpers of the playfair digram decipher
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

  localparam int SIDE     = 5;
  localparam int CODE_W   = 5;
  localparam int COORD_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int TDATA_W  = 16;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [COORD_W-1:0] coord_t;

  // column zero in the low bits
  typedef code_t [SIDE-1:0] row_t;
  typedef row_t  [SIDE-1:0] square_t;

  typedef logic [SIDE-1:0]   rowhit_t;
  typedef rowhit_t [SIDE-1:0] hit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ROW0 = 3'd0,
    REG_KEY_ROW1 = 3'd1,
    REG_KEY_ROW2 = 3'd2,
    REG_KEY_ROW3 = 3'd3,
    REG_KEY_ROW4 = 3'd4
  } cfg_reg_e;

  // A..E / F..K / L..P / Q..U / V..Z, no J
  localparam square_t KEY_RESET = {
    25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
  };

  typedef struct packed {
    hit_t hit_a;
    hit_t hit_b;
    logic fin;
  } match_t;

  typedef struct packed {
    coord_t ra;
    coord_t ca;
    coord_t rb;
    coord_t cb;
    logic   fa;
    logic   fb;
    logic   fin;
  } loc_t;

  typedef struct packed {
    coord_t ta_r;
    coord_t ta_c;
    coord_t tb_r;
    coord_t tb_c;
    logic   miss;
    logic   fin;
  } tgt_t;

  typedef struct packed {
    code_t pa;
    code_t pb;
    logic  miss;
    logic  fin;
  } res_t;

  // one step back around the square
  function automatic coord_t wrap_prev(coord_t x);
    coord_t r;
    if (x == '0) begin
      r = COORD_W'(SIDE - 1);
    end else begin
      r = x - COORD_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/pfd_match.sv
// ----------------------------------------------------------------------------
// pfd_match
// stage 1: compares both letters against all cells of the square
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_match (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire pfd_pkg::code_t   letter_a,
  input  wire pfd_pkg::code_t   letter_b,
  input  wire logic             fin,
  input  wire pfd_pkg::square_t square,
  output logic                  out_valid,
  output pfd_pkg::match_t       out_data
);

  pfd_pkg::match_t out_next;

  always_comb begin
    for (int r = 0; r < pfd_pkg::SIDE; r++) begin
      for (int c = 0; c < pfd_pkg::SIDE; c++) begin
        out_next.hit_a[r][c] = (square[r][c] == letter_a);
        out_next.hit_b[r][c] = (square[r][c] == letter_b);
      end
    end
    out_next.fin = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

>>> design/pfd_locate.sv
// ----------------------------------------------------------------------------
// pfd_locate
// stage 2: first hit in row-major order gives row and column of each letter
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_locate (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire pfd_pkg::match_t in_data,
  output logic                 out_valid,
  output pfd_pkg::loc_t        out_data
);

  pfd_pkg::loc_t out_next;

  function automatic void find_first(input pfd_pkg::hit_t hit, output pfd_pkg::coord_t row,
                                     output pfd_pkg::coord_t col, output logic found);
    pfd_pkg::rowhit_t sel;
    row   = '0;
    col   = '0;
    found = 1'b0;
    sel   = '0;
    // scan from the far end so the lowest match wins
    for (int r = pfd_pkg::SIDE - 1; r >= 0; r--) begin
      if (|hit[r]) begin
        row   = pfd_pkg::COORD_W'(r);
        sel   = hit[r];
        found = 1'b1;
      end
    end
    for (int c = pfd_pkg::SIDE - 1; c >= 0; c--) begin
      if (sel[c]) begin
        col = pfd_pkg::COORD_W'(c);
      end
    end
  endfunction

  always_comb begin
    find_first(in_data.hit_a, out_next.ra, out_next.ca, out_next.fa);
    find_first(in_data.hit_b, out_next.rb, out_next.cb, out_next.fb);
    out_next.fin = in_data.fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

>>> design/pfd_rule.sv
// ----------------------------------------------------------------------------
// pfd_rule
// stage 3: applies the row, column or rectangle rule to get target cells
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_rule (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire pfd_pkg::loc_t in_data,
  output logic               out_valid,
  output pfd_pkg::tgt_t      out_data
);

  pfd_pkg::tgt_t out_next;

  always_comb begin
    out_next.miss = !(in_data.fa && in_data.fb);
    out_next.fin  = in_data.fin;
    if (in_data.ra == in_data.rb) begin
      // same row: one column left
      out_next.ta_r = in_data.ra;
      out_next.ta_c = pfd_pkg::wrap_prev(in_data.ca);
      out_next.tb_r = in_data.rb;
      out_next.tb_c = pfd_pkg::wrap_prev(in_data.cb);
    end else if (in_data.ca == in_data.cb) begin
      // same column: one row up
      out_next.ta_r = pfd_pkg::wrap_prev(in_data.ra);
      out_next.ta_c = in_data.ca;
      out_next.tb_r = pfd_pkg::wrap_prev(in_data.rb);
      out_next.tb_c = in_data.cb;
    end else begin
      out_next.ta_r = in_data.ra;
      out_next.ta_c = in_data.cb;
      out_next.tb_r = in_data.rb;
      out_next.tb_c = in_data.ca;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

>>> design/pfd_lookup.sv
// ----------------------------------------------------------------------------
// pfd_lookup
// stage 4: reads the target cells and holds the result for the output
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_lookup (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire pfd_pkg::tgt_t    in_data,
  input  wire pfd_pkg::square_t square,
  output logic                  out_valid,
  output pfd_pkg::res_t         out_data
);

  pfd_pkg::res_t out_next;

  always_comb begin
    out_next.miss = in_data.miss;
    out_next.fin  = in_data.fin;
    if (in_data.miss) begin
      out_next.pa = '0;
      out_next.pb = '0;
    end else begin
      out_next.pa = square[in_data.ta_r][in_data.ta_c];
      out_next.pb = square[in_data.tb_r][in_data.tb_c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

>>> design/playfair_digram_decipher.sv
// ----------------------------------------------------------------------------
// playfair_digram_decipher
// deciphers one playfair digram per transfer against a 5x5 key square
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries a ciphertext digram, tlast marks the last digram of a
//   message. m_axis returns the plaintext digram, a missing-letter flag and
//   the copied tlast. the key square sits in five row registers written over
//   the cfg channel (index 0..4, other indexes ignored); write them only
//   while no digram is in flight.
//   an input transfer loads the compare stage, then locate, rule and cell
//   read follow one register stage each, four register stages in all; the
//   cell read register drives the result.
//   throughput is one digram per cycle; the four stages advance together
//   whenever the output register is empty or being taken.
//   when the receiver stalls, the whole pipe holds and s_axis_tready drops
//   in the same cycle, so nothing is lost or repeated.
//   reset empties the pipe and loads the square A..E / F..K / L..P / Q..U /
//   V..Z with J left out; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digram_decipher (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [pfd_pkg::TDATA_W-1:0]   s_axis_tdata,  // cipher_first, cipher_second, pad
  input  wire logic                          s_axis_tlast,  // final_pair
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [pfd_pkg::TDATA_W-1:0]        m_axis_tdata,  // plain_first, plain_second,
                                                            // letter_missing, pad
  output logic                               m_axis_tlast,  // final_pair_out
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [5*pfd_pkg::SIDE-1:0]    cfg_data
);

  pfd_pkg::square_t key_sq;
  logic             en;
  logic             v1, v2, v3;
  pfd_pkg::match_t  d1;
  pfd_pkg::loc_t    d2;
  pfd_pkg::tgt_t    d3;
  pfd_pkg::res_t    d4;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_sq <= pfd_pkg::KEY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pfd_pkg::cfg_reg_e'(cfg_index))
        pfd_pkg::REG_KEY_ROW0: key_sq[0] <= pfd_pkg::row_t'(cfg_data);
        pfd_pkg::REG_KEY_ROW1: key_sq[1] <= pfd_pkg::row_t'(cfg_data);
        pfd_pkg::REG_KEY_ROW2: key_sq[2] <= pfd_pkg::row_t'(cfg_data);
        pfd_pkg::REG_KEY_ROW3: key_sq[3] <= pfd_pkg::row_t'(cfg_data);
        pfd_pkg::REG_KEY_ROW4: key_sq[4] <= pfd_pkg::row_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // whole pipe advances when the output slot frees up
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  pfd_match u_match (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .letter_a  (s_axis_tdata[pfd_pkg::CODE_W-1:0]),
    .letter_b  (s_axis_tdata[2*pfd_pkg::CODE_W-1:pfd_pkg::CODE_W]),
    .fin       (s_axis_tlast),
    .square    (key_sq),
    .out_valid (v1),
    .out_data  (d1)
  );

  pfd_locate u_locate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .in_data   (d1),
    .out_valid (v2),
    .out_data  (d2)
  );

  pfd_rule u_rule (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_data   (d2),
    .out_valid (v3),
    .out_data  (d3)
  );

  pfd_lookup u_lookup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_data   (d3),
    .square    (key_sq),
    .out_valid (m_axis_tvalid),
    .out_data  (d4)
  );

  assign m_axis_tdata = {
    {(pfd_pkg::TDATA_W - 2*pfd_pkg::CODE_W - 1){1'b0}}, d4.miss, d4.pb, d4.pa
  };
  assign m_axis_tlast = d4.fin;

endmodule

`default_nettype wire

>>> design/pfd_checker.sv
// ----------------------------------------------------------------------------
// pfd_checker
// port-level checks of the playfair digram decipher
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [pfd_pkg::TDATA_W-1:0]   s_axis_tdata,
  input wire logic                          s_axis_tlast,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [pfd_pkg::TDATA_W-1:0]   m_axis_tdata,
  input wire logic                          m_axis_tlast,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready,
  input wire logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [5*pfd_pkg::SIDE-1:0]    cfg_data
);

  // pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // input side only stalls when the output slot is held
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not track output slot");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // missing letter gives zero plaintext
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2*pfd_pkg::CODE_W] |->
      m_axis_tdata[2*pfd_pkg::CODE_W-1:0] == '0)
    else $error("plaintext not cleared on missing letter");

endmodule

bind playfair_digram_decipher pfd_checker u_pfd_checker (.*);

`default_nettype wire
